@@ hdl/lsrg_pkg.sv @@
// Shared types and constants for the linear speed ramp generator.
package lsrg_pkg;

  localparam int StepWidth = 16;
  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;
  localparam int IdxWidth  = AddrWidth - 2;

  typedef logic [StepWidth-1:0] step_t;
  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [DataWidth-1:0] data_t;
  typedef logic [IdxWidth-1:0]  reg_idx_t;

  localparam step_t    StepReset    = 16'd256;
  localparam reg_idx_t RegAccelStep = 1'd0;

endpackage

@@ hdl/lsrg_cfg.sv @@
// APB-style register file holding the per-tick acceleration step.
module lsrg_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  lsrg_pkg::addr_t paddr,
  input  lsrg_pkg::data_t pwdata,
  output lsrg_pkg::data_t prdata,
  output logic           pready,
  output lsrg_pkg::step_t step_o
);
  import lsrg_pkg::*;

  step_t    step_q;
  step_t    step_d;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[AddrWidth-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (idx == RegAccelStep);

  always_comb begin
    step_d = step_q;
    if (wr_en) begin
      step_d = pwdata[StepWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == RegAccelStep) begin
      prdata = {{(DataWidth - StepWidth){1'b0}}, step_q};
    end
  end

  assign step_o = step_q;
endmodule

@@ hdl/lsrg_ramp.sv @@
// Ramp state and single-pass setpoint update, one item per enabled cycle.
module lsrg_ramp #(
  parameter int SpeedWidth = 20,
  parameter int CountWidth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic signed [SpeedWidth-1:0] target_i,
  input  lsrg_pkg::step_t              step_i,
  output logic signed [SpeedWidth-1:0] speed_o,
  output logic                         done_o
);
  import lsrg_pkg::*;

  localparam int ProdWidth = CountWidth + StepWidth;
  localparam int CmpWidth  = (ProdWidth + 1 > SpeedWidth + 1) ? ProdWidth + 1 : SpeedWidth + 1;

  logic signed [SpeedWidth-1:0] start_q, start_d;
  logic signed [SpeedWidth-1:0] held_q, held_d;
  logic signed [SpeedWidth-1:0] cur_q, cur_d;
  logic [CountWidth-1:0]        cnt_q, cnt_d;
  logic                         done_q, done_d;

  logic                         retarget;
  logic signed [SpeedWidth-1:0] start0;
  logic [CountWidth-1:0]        cnt0;
  logic                         rising;
  logic [SpeedWidth:0]          s_ext, t_ext, dist_mag;
  logic [ProdWidth-1:0]         prod0;
  logic                         inc;
  logic [ProdWidth:0]           delta;
  logic [CmpWidth-1:0]          dist_c, prod_c, delta_c;
  logic [SpeedWidth:0]          moved;

  always_comb begin
    retarget = (target_i != held_q);
    start0   = retarget ? cur_q : start_q;
    cnt0     = retarget ? '0 : cnt_q;
    rising   = (start0 < target_i);
    s_ext    = {start0[SpeedWidth-1], start0};
    t_ext    = {target_i[SpeedWidth-1], target_i};
    dist_mag = rising ? (t_ext - s_ext) : (s_ext - t_ext);
    prod0    = ProdWidth'(cnt0) * ProdWidth'(step_i);
    inc      = (cnt0 != '1);
    delta    = {1'b0, prod0} + (inc ? (ProdWidth + 1)'(step_i) : '0);
    dist_c   = CmpWidth'(dist_mag);
    prod_c   = CmpWidth'(prod0);
    delta_c  = CmpWidth'(delta);
    moved    = rising ? (s_ext + delta_c[SpeedWidth:0]) : (s_ext - delta_c[SpeedWidth:0]);

    start_d = start_q;
    held_d  = held_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    if (adv_i) begin
      held_d = target_i;
      start_d = start0;
      cnt_d = cnt0;
      if (prod_c >= dist_c) begin
        done_d  = 1'b1;
        start_d = target_i;
        cur_d   = target_i;
      end else begin
        cnt_d = cnt0 + {{(CountWidth - 1){1'b0}}, inc};
        if (delta_c >= dist_c) begin
          done_d  = 1'b1;
          start_d = target_i;
          cur_d   = target_i;
        end else begin
          done_d = 1'b0;
          cur_d  = moved[SpeedWidth-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      held_q  <= '0;
      cur_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      start_q <= start_d;
      held_q  <= held_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign speed_o = cur_q;
  assign done_o  = done_q;
endmodule

@@ hdl/linear_speed_ramp_generator_unit.sv @@
// Top level of the linear speed ramp generator.
// One beat on the input channel carries a target speed for one control tick;
// one beat on the output channel carries the ramped setpoint and a done flag.
// Both channels use valid and stall: a beat moves on a rising edge with valid
// high and stall low. The acceleration step per tick is written over the APB
// port at address 0 and may only be changed while the block is idle.
// An input beat is captured in an input register and the ramp update runs from
// it once the result register is free or not stalled, landing in the result
// register. One beat is taken every cycle while the receiver does not stall,
// as the ramp update is one pass of a single multiply and its compares.
// While the receiver stalls, the result register holds and the input register
// keeps one more beat; input stall rises only when both are full.
// Reset clears the ramp state to zero speed, empties both registers and loads
// the default step of 256 speed units per tick.
module linear_speed_ramp_generator_unit #(
  parameter int SPEED_WIDTH = 20,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SPEED_WIDTH-1:0] target_speed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SPEED_WIDTH-1:0] ramp_speed_o,
  output logic                          ramp_done_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  lsrg_pkg::addr_t               paddr,
  input  lsrg_pkg::data_t               pwdata,
  output lsrg_pkg::data_t               prdata,
  output logic                          pready
);
  import lsrg_pkg::*;

  step_t                         step;
  logic                          in_vld_q, in_vld_d;
  logic signed [SPEED_WIDTH-1:0] in_tgt_q, in_tgt_d;
  logic                          res_vld_q, res_vld_d;
  logic                          adv;

  lsrg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .step_o  (step)
  );

  lsrg_ramp #(
    .SpeedWidth (SPEED_WIDTH),
    .CountWidth (COUNT_WIDTH)
  ) u_ramp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .target_i (in_tgt_q),
    .step_i   (step),
    .speed_o  (ramp_speed_o),
    .done_o   (ramp_done_o)
  );

  assign adv        = in_vld_q && (!res_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_tgt_d  = in_tgt_q;
    res_vld_d = res_vld_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
      in_tgt_d = target_speed_i;
    end
    if (adv) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_tgt_q <= in_tgt_d;
  end

  assign out_valid_o = res_vld_q;
endmodule

@@ tb/linear_speed_ramp_generator_unit_test.sv @@
// Self-checking testbench for the linear speed ramp generator with a ramp predictor.
`timescale 1ns / 1ps

module linear_speed_ramp_generator_unit_test;
  import lsrg_pkg::*;

  localparam int SpeedWidth = 20;
  localparam longint SpeedMin = -(longint'(1) << (SpeedWidth - 1));
  localparam longint SpeedMax = (longint'(1) << (SpeedWidth - 1)) - 1;
  localparam longint unsigned TickMax = 65535;
  localparam reg_idx_t RegUnused = 1'd1;
  localparam int MaxLines = 30;

  typedef logic signed [SpeedWidth-1:0] speed_t;

  typedef struct packed {
    speed_t speed;
    logic   done;
  } setpoint_t;

  class ramp_scoreboard;
    int unsigned mismatches;
    int unsigned targets_taken;
    int unsigned setpoints_checked;
    int unsigned done_checked;
    step_t step;
    longint start_spd;
    longint held_tgt;
    longint cur_spd;
    longint unsigned ticks;
    bit done;
    setpoint_t setpoint_q[$];

    function new();
      step = StepReset;
      start_spd = 0;
      held_tgt = 0;
      cur_spd = 0;
      ticks = 0;
      done = 1'b0;
    endfunction

    function int pending();
      return setpoint_q.size();
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MaxLines) $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    function void note_target(input speed_t target);
      longint tgt;
      longint unsigned remaining;
      longint unsigned delta;
      bit rising;
      setpoint_t sp;
      tgt = target;
      if (tgt != held_tgt) begin
        ticks = 0;
        done = 1'b0;
        start_spd = cur_spd;
      end
      held_tgt = tgt;
      rising = start_spd < tgt;
      remaining = rising ? longint'(tgt - start_spd) : longint'(start_spd - tgt);
      if (ticks * step >= remaining) begin
        done = 1'b1;
        start_spd = tgt;
        cur_spd = tgt;
      end else begin
        if (ticks < TickMax) ticks++;
        delta = ticks * step;
        if (delta >= remaining) begin
          done = 1'b1;
          start_spd = tgt;
          cur_spd = tgt;
        end else if (rising) begin
          cur_spd = start_spd + longint'(delta);
        end else begin
          cur_spd = start_spd - longint'(delta);
        end
      end
      sp.speed = speed_t'(cur_spd);
      sp.done = done;
      setpoint_q.push_back(sp);
      targets_taken++;
    endfunction

    task check_result(input speed_t speed, input logic dn);
      setpoint_t sp;
      if (setpoint_q.size() == 0) begin
        report($sformatf("setpoint beat %0d with nothing expected", speed));
      end else begin
        sp = setpoint_q.pop_front();
        setpoints_checked++;
        if (sp.done) done_checked++;
        if (speed !== sp.speed)
          report($sformatf("ramp_speed %0d, expected %0d", speed, sp.speed));
        if (dn !== sp.done)
          report($sformatf("ramp_done %b, expected %b", dn, sp.done));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  speed_t target = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  speed_t ramp_speed;
  logic ramp_done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  addr_t paddr = '0;
  data_t pwdata = '0;
  data_t prdata;
  logic pready;

  bit idle_on = 1'b0;
  int unsigned reg_writes = 0;
  ramp_scoreboard sb = new();

  linear_speed_ramp_generator_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .target_speed_i (target),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .ramp_speed_o   (ramp_speed),
    .ramp_done_o    (ramp_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_target(input speed_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target <= t;
    do @(posedge clk); while (in_stall);
    sb.note_target(t);
  endtask

  task automatic send_run(input speed_t t, input int n);
    repeat (n) send_target(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input bit wr, input data_t wdata,
                            output data_t rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic config_write(input reg_idx_t idx, input data_t value);
    data_t rd;
    drain();
    apb_access(idx, 1'b1, value, rd);
    reg_writes++;
    if (idx == RegAccelStep) sb.step = value[StepWidth-1:0];
    apb_access(RegAccelStep, 1'b0, '0, rd);
    if (rd !== data_t'(sb.step))
      sb.report($sformatf("accel_step reads %0h, expected %0h", rd, sb.step));
  endtask

  function automatic speed_t pick_target();
    longint span;
    longint tgt;
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      span = longint'(sb.step) * $urandom_range(0, 24) + $urandom_range(0, 300);
      tgt = $urandom_range(0, 1) ? sb.cur_spd + span : sb.cur_spd - span;
      if (tgt > SpeedMax) tgt = SpeedMax;
      if (tgt < SpeedMin) tgt = SpeedMin;
    end else if (r < 88) begin
      tgt = speed_t'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: tgt = SpeedMin;
        1: tgt = SpeedMax;
        2: tgt = 0;
        default: tgt = -1;
      endcase
    end
    return speed_t'(tgt);
  endfunction

  initial begin
    wait (rst_n);
    forever begin
      int stall_cycles;
      stall_cycles = idle_on ? $urandom_range(0, 13) : 0;
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(ramp_speed, ramp_done);
    end
  end

  initial begin
    #10ms;
    $display("FAIL linear_speed_ramp_generator_unit");
    $finish;
  end

  initial begin
    step_t phase_steps[$];
    int taken;
    int run_len;
    speed_t t;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset state, clamped final step, retarget mid ramp, zero and full steps, unused register.
    send_run(speed_t'(0), 1);
    send_run(speed_t'(1000), 5);
    send_run(speed_t'(SpeedMax), 2);
    send_run(speed_t'(SpeedMin), 3);
    config_write(RegAccelStep, 32'h0000_0000);
    send_run(speed_t'(SpeedMin), 1);
    send_run(speed_t'(777), 3);
    config_write(RegAccelStep, 32'hFFFF_FFFF);
    send_run(speed_t'(SpeedMax), 3);
    send_run(speed_t'(SpeedMin), 2);
    config_write(RegUnused, 32'h0000_0001);
    send_run(speed_t'(SpeedMin), 1);
    config_write(RegAccelStep, 32'hABCD_0100);

    // Random phases with well-formed ramps, short retargets and random targets.
    phase_steps = '{16'd1, 16'd65535, 16'd0, 16'd256, 16'd7, 16'd40000,
                    step_t'($urandom_range(1, 65535)), step_t'($urandom_range(1, 64))};
    foreach (phase_steps[p]) begin
      config_write(RegAccelStep, {16'($urandom), phase_steps[p]});
      taken = 0;
      while (taken < 250) begin
        idle_on = $urandom_range(0, 3) != 0;
        t = pick_target();
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        send_run(t, run_len);
        taken += run_len;
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    // Full-scale swings at the largest and the unit step.
    idle_on = 1'b0;
    config_write(RegAccelStep, 32'h0000_FFFF);
    send_run(speed_t'(SpeedMax), 20);
    config_write(RegAccelStep, 32'h0000_0001);
    send_run(speed_t'(SpeedMin), 40);
    idle_on = 1'b1;
    send_run(speed_t'(0), 12);

    drain();
    repeat (8) @(posedge clk);
    $display("Took %0d target beats and checked %0d setpoint beats, %0d with done set.",
             sb.targets_taken, sb.setpoints_checked, sb.done_checked);
    $display("Made %0d register writes, covering zero, unit and full-scale steps.",
             reg_writes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS linear_speed_ramp_generator_unit");
    end else begin
      $display("FAIL linear_speed_ramp_generator_unit");
    end
    $finish;
  end

endmodule
